>>> rtl/smf_pkg.sv
package smf_pkg;

	typedef enum logic [2:0] {
		PH_DELTA,
		PH_STATUS,
		PH_DATA1,
		PH_DATA2,
		PH_MTYPE,
		PH_LEN,
		PH_PAYLOAD
	} phase_t;

	localparam logic [2:0] KIND_CHANNEL = 3'd0;
	localparam logic [2:0] KIND_META    = 3'd1;
	localparam logic [2:0] KIND_SYSEX   = 3'd2;
	localparam logic [2:0] KIND_PAYLOAD = 3'd3;
	localparam logic [2:0] KIND_NO_STAT = 3'd4;

	localparam logic [7:0] STATUS_META  = 8'hFF;
	localparam logic [7:0] META_TEMPO   = 8'h51;
	localparam logic [7:0] ONE_DATA_MSK = 8'hE0;
	localparam logic [7:0] ONE_DATA_VAL = 8'hC0;
	localparam logic [1:0] TEMPO_LAST   = 2'd2;
	localparam logic [1:0] INDEX_MAX    = 2'd3;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] delta_time;
		logic [7:0]  status_byte;
		logic [7:0]  data_one;
		logic [7:0]  data_two;
		logic [7:0]  meta_kind;
		logic [31:0] payload_length;
		logic [7:0]  payload_byte;
		logic        payload_last;
		logic [23:0] tempo_value;
		logic        tempo_valid;
	} res_t;

endpackage

>>> rtl/smf_parser.sv
module smf_parser
	import smf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] track_byte,
	input  logic       track_start,
	input  logic       pass_payload,
	output logic       res_valid,
	output res_t       res
);

	phase_t      phase_q, phase_d, ph;
	logic [7:0]  rs_q, rs_d, rs;
	logic        known_q, known_d, known;
	logic [31:0] vlq_q, vlq_d, vlq, vlq_shift;
	logic [31:0] delta_q, delta_d;
	logic [7:0]  d1_q, d1_d;
	logic [7:0]  hstat_q, hstat_d;
	logic [7:0]  hmeta_q, hmeta_d;
	logic [31:0] rem_q, rem_d, rem;
	logic [23:0] tempo_q, tempo_d, tempo;
	logic [1:0]  idx_q, idx_d, idx;
	logic        one_data, tempo_meta, last, done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DELTA;
			rs_q    <= '0;
			known_q <= 1'b0;
			vlq_q   <= '0;
			delta_q <= '0;
			d1_q    <= '0;
			hstat_q <= '0;
			hmeta_q <= '0;
			rem_q   <= '0;
			tempo_q <= '0;
			idx_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			rs_q    <= rs_d;
			known_q <= known_d;
			vlq_q   <= vlq_d;
			delta_q <= delta_d;
			d1_q    <= d1_d;
			hstat_q <= hstat_d;
			hmeta_q <= hmeta_d;
			rem_q   <= rem_d;
			tempo_q <= tempo_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		ph    = phase_q;
		rs    = rs_q;
		known = known_q;
		vlq   = vlq_q;
		tempo = tempo_q;
		idx   = idx_q;
		rem   = rem_q;
		if (track_start) begin
			ph    = PH_DELTA;
			rs    = '0;
			known = 1'b0;
			vlq   = '0;
			tempo = '0;
			idx   = '0;
			rem   = '0;
		end

		vlq_shift  = {vlq[24:0], track_byte[6:0]};
		one_data   = (rs & ONE_DATA_MSK) == ONE_DATA_VAL;
		tempo_meta = (hstat_q == STATUS_META) && (hmeta_q == META_TEMPO);
		last       = (rem[31:1] == '0);
		done       = tempo_meta && (idx == TEMPO_LAST);

		phase_d = ph;
		rs_d    = rs;
		known_d = known;
		vlq_d   = vlq;
		delta_d = delta_q;
		d1_d    = d1_q;
		hstat_d = hstat_q;
		hmeta_d = hmeta_q;
		rem_d   = rem;
		tempo_d = tempo;
		idx_d   = idx;

		res_valid = 1'b0;
		res       = '0;

		case (ph)
			PH_DELTA: begin
				vlq_d = vlq_shift;
				if (!track_byte[7]) begin
					delta_d = vlq_shift;
					vlq_d   = '0;
					phase_d = PH_STATUS;
				end
			end
			PH_STATUS: begin
				if (track_byte[7:4] == 4'hF) begin
					hstat_d = track_byte;
					hmeta_d = '0;
					vlq_d   = '0;
					phase_d = (track_byte == STATUS_META) ? PH_MTYPE : PH_LEN;
				end else if (track_byte[7]) begin
					rs_d    = track_byte;
					known_d = 1'b1;
					phase_d = PH_DATA1;
				end else if (!known) begin
					res_valid      = 1'b1;
					res.kind       = KIND_NO_STAT;
					res.delta_time = delta_q;
					res.data_one   = track_byte;
					phase_d        = PH_DELTA;
				end else begin
					d1_d = track_byte;
					if (one_data) begin
						res_valid       = 1'b1;
						res.kind        = KIND_CHANNEL;
						res.delta_time  = delta_q;
						res.status_byte = rs;
						res.data_one    = track_byte;
						phase_d         = PH_DELTA;
					end else begin
						phase_d = PH_DATA2;
					end
				end
			end
			PH_DATA1: begin
				d1_d = track_byte;
				if (one_data) begin
					res_valid       = 1'b1;
					res.kind        = KIND_CHANNEL;
					res.delta_time  = delta_q;
					res.status_byte = rs;
					res.data_one    = track_byte;
					phase_d         = PH_DELTA;
				end else begin
					phase_d = PH_DATA2;
				end
			end
			PH_DATA2: begin
				res_valid       = 1'b1;
				res.kind        = KIND_CHANNEL;
				res.delta_time  = delta_q;
				res.status_byte = rs;
				res.data_one    = d1_q;
				res.data_two    = track_byte;
				phase_d         = PH_DELTA;
			end
			PH_MTYPE: begin
				hmeta_d = track_byte;
				vlq_d   = '0;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				vlq_d = vlq_shift;
				if (!track_byte[7]) begin
					rem_d              = vlq_shift;
					vlq_d              = '0;
					tempo_d            = '0;
					idx_d              = '0;
					res_valid          = 1'b1;
					res.kind           = (hstat_q == STATUS_META) ? KIND_META : KIND_SYSEX;
					res.delta_time     = delta_q;
					res.status_byte    = hstat_q;
					res.meta_kind      = hmeta_q;
					res.payload_length = vlq_shift;
					phase_d            = (vlq_shift == '0) ? PH_DELTA : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (tempo_meta && (idx != INDEX_MAX)) begin
					tempo_d = {tempo[15:0], track_byte};
				end
				if (idx != INDEX_MAX) begin
					idx_d = idx + 2'd1;
				end
				rem_d = last ? '0 : rem - 32'd1;
				if (last) begin
					phase_d = PH_DELTA;
				end
				if (pass_payload || done) begin
					res_valid         = 1'b1;
					res.kind          = KIND_PAYLOAD;
					res.delta_time    = delta_q;
					res.status_byte   = hstat_q;
					res.meta_kind     = hmeta_q;
					res.payload_byte  = track_byte;
					res.payload_last  = last;
					if (done) begin
						res.tempo_value = {tempo[15:0], track_byte};
						res.tempo_valid = 1'b1;
					end
				end
			end
			default: begin
				phase_d = PH_DELTA;
			end
		endcase
	end

endmodule

>>> rtl/smf_out_buf.sv
module smf_out_buf
	import smf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	output logic full,
	output logic out_valid,
	input  logic out_stall,
	output res_t out_data
);

	res_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign out_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign pop       = out_valid && !out_stall;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/smf_track_event_parser.sv
// each result is decoded from the byte held in the input register and presented from the result buffer
// throughput: one track byte per cycle while in_stall is low; a two-entry result buffer absorbs output stall
// input stalls only while the input register is held and the result buffer is full
// reset: asynchronous active low; clears parser state, running status and buffers
// pass_payload comes out of reset as 1
module smf_track_event_parser
	import smf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  track_byte,
	input  logic        track_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [31:0] delta_time,
	output logic [7:0]  status_byte,
	output logic [7:0]  data_one,
	output logic [7:0]  data_two,
	output logic [7:0]  meta_kind,
	output logic [31:0] payload_length,
	output logic [7:0]  payload_byte,
	output logic        payload_last,
	output logic [23:0] tempo_value,
	output logic        tempo_valid
);

	logic       pass_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       buf_full, fire, accept;
	logic       res_valid;
	res_t       res, out_res;

	assign in_stall = valid_s1 && buf_full;
	assign accept   = in_valid && !in_stall;
	assign fire     = valid_s1 && !buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q   <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_write) begin
				pass_q <= cfg_data;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= track_byte;
			start_s1 <= track_start;
		end
	end

	smf_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.track_byte   (byte_s1),
		.track_start  (start_s1),
		.pass_payload (pass_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	smf_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire && res_valid),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign kind           = out_res.kind;
	assign delta_time     = out_res.delta_time;
	assign status_byte    = out_res.status_byte;
	assign data_one       = out_res.data_one;
	assign data_two       = out_res.data_two;
	assign meta_kind      = out_res.meta_kind;
	assign payload_length = out_res.payload_length;
	assign payload_byte   = out_res.payload_byte;
	assign payload_last   = out_res.payload_last;
	assign tempo_value    = out_res.tempo_value;
	assign tempo_valid    = out_res.tempo_valid;

endmodule

>>> tb/sv/tb_smf_track_event_parser.sv
`timescale 1ns / 1ps

module tb_smf_track_event_parser;
	import smf_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam logic [7:0] SYSTEM_FLOOR = 8'hF0;
	localparam logic [7:0] STATUS_BIT = 8'h80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic cfg_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] track_byte = '0;
	logic track_start = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] kind;
	logic [31:0] delta_time;
	logic [7:0] status_byte;
	logic [7:0] data_one;
	logic [7:0] data_two;
	logic [7:0] meta_kind;
	logic [31:0] payload_length;
	logic [7:0] payload_byte;
	logic payload_last;
	logic [23:0] tempo_value;
	logic tempo_valid;

	smf_track_event_parser dut (.*);

	always #5 clk = ~clk;

	// parser image
	phase_t parse_phase = PH_DELTA;
	logic [7:0] run_status = '0;
	bit status_seen = 1'b0;
	logic [31:0] vlq_acc = '0;
	logic [31:0] event_delta = '0;
	logic [7:0] first_data = '0;
	logic [7:0] event_status = '0;
	logic [7:0] event_meta = '0;
	logic [31:0] remaining = '0;
	logic [23:0] tempo_acc = '0;
	logic [1:0] pay_idx = '0;
	bit pass_payload_cfg = 1'b1;

	res_t pending_events[$];
	int mismatches = 0;
	bit in_gaps = 1'b1;
	bit out_gaps = 1'b1;
	bit long_hold_req = 1'b0;

	function automatic bit decode_track_byte(input logic [7:0] b, input logic s, output res_t r);
		bit emit, chan, data_first, tempo_meta, tempo_done, last_byte;
		logic [7:0] second;
		r = '0;
		emit = 1'b0;
		chan = 1'b0;
		data_first = 1'b0;
		second = '0;
		if (s) begin
			parse_phase = PH_DELTA;
			run_status = '0;
			status_seen = 1'b0;
			vlq_acc = '0;
			tempo_acc = '0;
			pay_idx = '0;
			remaining = '0;
		end
		case (parse_phase)
			PH_DELTA: begin
				vlq_acc = (vlq_acc << 7) + 32'(b[6:0]);
				if (!b[7]) begin
					event_delta = vlq_acc;
					vlq_acc = '0;
					parse_phase = PH_STATUS;
				end
			end
			PH_STATUS: begin
				if (b >= SYSTEM_FLOOR) begin
					event_status = b;
					event_meta = '0;
					vlq_acc = '0;
					parse_phase = (b == STATUS_META) ? PH_MTYPE : PH_LEN;
				end else if (b[7]) begin
					run_status = b;
					status_seen = 1'b1;
					parse_phase = PH_DATA1;
				end else if (!status_seen) begin
					r.kind = KIND_NO_STAT;
					r.delta_time = event_delta;
					r.data_one = b;
					parse_phase = PH_DELTA;
					emit = 1'b1;
				end else begin
					data_first = 1'b1;
				end
			end
			PH_DATA1: data_first = 1'b1;
			PH_DATA2: begin
				second = b;
				chan = 1'b1;
			end
			PH_MTYPE: begin
				event_meta = b;
				vlq_acc = '0;
				parse_phase = PH_LEN;
			end
			PH_LEN: begin
				vlq_acc = (vlq_acc << 7) + 32'(b[6:0]);
				if (!b[7]) begin
					remaining = vlq_acc;
					vlq_acc = '0;
					tempo_acc = '0;
					pay_idx = '0;
					r.kind = (event_status == STATUS_META) ? KIND_META : KIND_SYSEX;
					r.delta_time = event_delta;
					r.status_byte = event_status;
					r.meta_kind = event_meta;
					r.payload_length = remaining;
					parse_phase = (remaining == 0) ? PH_DELTA : PH_PAYLOAD;
					emit = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				tempo_meta = (event_status == STATUS_META) && (event_meta == META_TEMPO);
				tempo_done = 1'b0;
				last_byte = (remaining <= 1);
				if (tempo_meta && pay_idx < INDEX_MAX) begin
					tempo_acc = {tempo_acc[15:0], b};
					tempo_done = (pay_idx == TEMPO_LAST);
				end
				if (pay_idx < INDEX_MAX)
					pay_idx++;
				remaining = last_byte ? 32'd0 : remaining - 1;
				if (last_byte)
					parse_phase = PH_DELTA;
				if (pass_payload_cfg || tempo_done) begin
					r.kind = KIND_PAYLOAD;
					r.delta_time = event_delta;
					r.status_byte = event_status;
					r.meta_kind = event_meta;
					r.payload_byte = b;
					r.payload_last = last_byte;
					if (tempo_done) begin
						r.tempo_value = tempo_acc;
						r.tempo_valid = 1'b1;
					end
					emit = 1'b1;
				end
			end
			default: parse_phase = PH_DELTA;
		endcase
		if (data_first) begin
			first_data = b;
			if ((run_status & ONE_DATA_MSK) == ONE_DATA_VAL)
				chan = 1'b1;
			else
				parse_phase = PH_DATA2;
		end
		if (chan) begin
			r.kind = KIND_CHANNEL;
			r.delta_time = event_delta;
			r.status_byte = run_status;
			r.data_one = first_data;
			r.data_two = second;
			parse_phase = PH_DELTA;
			emit = 1'b1;
		end
		return emit;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic s);
		int gap;
		bit stalled;
		res_t r;
		gap = in_gaps ? int'($urandom_range(0, 13)) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		track_byte <= b;
		track_start <= s;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		if (decode_track_byte(b, s, r))
			pending_events.push_back(r);
	endtask

	task automatic settle_parser();
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_pass_payload(input bit v);
		settle_parser();
		cfg_data <= v;
		cfg_write <= 1'b1;
		@(posedge clk);
		cfg_write <= 1'b0;
		pass_payload_cfg = v;
	endtask

	task automatic send_channel_data();
		int n;
		n = ((run_status & ONE_DATA_MSK) == ONE_DATA_VAL) ? 1 : 2;
		repeat (n) begin
			if ($urandom_range(0, 15) == 0)
				send_byte(8'($urandom_range(0, 255)), 1'b0);
			else
				send_byte(8'($urandom_range(0, 127)), 1'b0);
		end
	endtask

	task automatic send_payload();
		int len;
		len = ($urandom_range(0, 4) == 0) ? int'($urandom_range(7, 20))
			: int'($urandom_range(0, 6));
		// padded length encoding
		repeat (($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0)
			send_byte(STATUS_BIT, 1'b0);
		send_byte(8'(len), 1'b0);
		repeat (len)
			send_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	task automatic send_random_event();
		int n, sel;
		bit s;
		logic [7:0] b;
		// resync with a track start now and then
		if (parse_phase != PH_DELTA)
			s = 1'($urandom_range(0, 1));
		else
			s = ($urandom_range(0, 24) == 0);
		n = ($urandom_range(0, 7) == 0) ? int'($urandom_range(2, 6)) : 1;
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom_range(0, 127));
			if (i < n - 1)
				b[7] = 1'b1;
			send_byte(b, s && i == 0);
		end
		sel = int'($urandom_range(0, 99));
		if (sel < 35) begin
			send_byte(8'($urandom_range(8'h80, 8'hEF)), 1'b0);
			send_channel_data();
		end else if (sel < 55) begin
			send_channel_data();
		end else if (sel < 70) begin
			send_byte(STATUS_META, 1'b0);
			if ($urandom_range(0, 2) == 0)
				send_byte(META_TEMPO, 1'b0);
			else
				send_byte(8'($urandom_range(0, 255)), 1'b0);
			send_payload();
		end else if (sel < 85) begin
			send_byte(8'($urandom_range(8'hF0, 8'hFE)), 1'b0);
			send_payload();
		end else begin
			repeat ($urandom_range(1, 3))
				send_byte(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	task automatic test_directed_events();
		// {track_start, byte}
		logic [8:0] script [0:27] = '{
			9'h100, 9'h090, 9'h03C, 9'h07F,
			9'h000, 9'h0C5, 9'h010,
			9'h08F, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F, 9'h0EF, 9'h080, 9'h0FF,
			9'h000, 9'h0FF, 9'h051, 9'h003, 9'h007, 9'h0A1, 9'h020,
			9'h000, 9'h0F0, 9'h000,
			9'h100, 9'h045
		};
		foreach (script[i])
			send_byte(script[i][7:0], script[i][8]);
	endtask

	task automatic test_payload_gated();
		write_pass_payload(1'b0);
		repeat (35) send_random_event();
	endtask

	task automatic test_back_to_back();
		in_gaps = 1'b0;
		out_gaps = 1'b0;
		repeat (25) send_random_event();
		in_gaps = 1'b1;
		out_gaps = 1'b1;
	endtask

	task automatic test_payload_passed();
		write_pass_payload(1'b1);
		repeat (45) send_random_event();
	endtask

	task automatic test_output_hold_off();
		in_gaps = 1'b0;
		long_hold_req = 1'b1;
		repeat (30) send_random_event();
		in_gaps = 1'b1;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_events();
		test_payload_gated();
		test_back_to_back();
		test_payload_passed();
		test_output_hold_off();
		settle_parser();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : result_checker
		int hold;
		bit got;
		res_t seen, want;
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				hold = out_gaps ? int'($urandom_range(0, 13)) : 0;
				if (hold > 0) begin
					out_stall <= 1'b1;
					repeat (hold) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			do begin
				@(negedge clk);
				got = out_valid;
				seen = {kind, delta_time, status_byte, data_one, data_two, meta_kind,
					payload_length, payload_byte, payload_last, tempo_value, tempo_valid};
				@(posedge clk);
			end while (!got);
			if (pending_events.size() == 0) begin
				$error("result transaction with nothing expected, kind %0d", seen.kind);
				mismatches++;
			end else begin
				want = pending_events.pop_front();
				check_field("kind", 32'(want.kind), 32'(seen.kind));
				check_field("delta_time", want.delta_time, seen.delta_time);
				check_field("status_byte", 32'(want.status_byte), 32'(seen.status_byte));
				check_field("data_one", 32'(want.data_one), 32'(seen.data_one));
				check_field("data_two", 32'(want.data_two), 32'(seen.data_two));
				check_field("meta_kind", 32'(want.meta_kind), 32'(seen.meta_kind));
				check_field("payload_length", want.payload_length, seen.payload_length);
				check_field("payload_byte", 32'(want.payload_byte), 32'(seen.payload_byte));
				check_field("payload_last", 32'(want.payload_last), 32'(seen.payload_last));
				check_field("tempo_value", 32'(want.tempo_value), 32'(seen.tempo_value));
				check_field("tempo_valid", 32'(want.tempo_valid), 32'(seen.tempo_valid));
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(negedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

endmodule

>>> smf_track_event_parser.f
rtl/smf_pkg.sv
rtl/smf_parser.sv
rtl/smf_out_buf.sv
rtl/smf_track_event_parser.sv
tb/sv/tb_smf_track_event_parser.sv
